[sv/pab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_pkg: shared types and constants of the parabolic arc breakpoint core
// Coordinate width, derived widths of the exact datapath and the records
// that move between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package pab_pkg;

	localparam int CW       = 32;
	localparam int OFFW     = 16;
	localparam logic [OFFW-1:0] OFF_RESET = OFFW'(1);

	localparam int UW       = CW + 3;
	localparam int AW       = CW + 1;
	localparam int HW       = CW + 1;
	localparam int BW       = 2 * CW + 4;
	localparam int DDW      = 2 * HW;
	localparam int UVW      = 2 * HW;
	localparam int RADW     = 4 * HW;
	localparam int SQW      = RADW / 2;
	localparam int RW       = SQW + 2;
	localparam int NW       = BW + 1;
	localparam int NMW      = NW - 1;
	localparam int DMW      = CW;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	typedef struct packed {
		logic                 side;
		logic                 eq;
		logic                 xlt;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] p1y;
		logic signed [CW-1:0] p2y;
		logic signed [UW-1:0] u;
		logic signed [UW-1:0] v;
		logic signed [AW-1:0] a;
	} fq_rec_t;

	typedef struct packed {
		logic                 side;
		logic                 eq;
		logic                 xlt;
		logic                 asign;
		logic [DMW-1:0]       amag;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] mean;
		logic signed [BW-1:0] b;
	} sq_side_t;

	typedef struct packed {
		logic                 side;
		logic                 eq;
		logic                 xlt;
		logic                 neg_p;
		logic                 neg_n;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] mean;
	} dv_side_t;

endpackage
`default_nettype wire

[sv/pab_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_in_if: query channel
// Valid/ready channel carrying one breakpoint or side-test query.
// ----------------------------------------------------------------------------
interface pab_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [pab_pkg::CW-1:0] sweep_pos;
	logic signed [pab_pkg::CW-1:0] query_y;
	logic signed [pab_pkg::CW-1:0] left_x;
	logic signed [pab_pkg::CW-1:0] left_y;
	logic signed [pab_pkg::CW-1:0] right_x;
	logic signed [pab_pkg::CW-1:0] right_y;

	modport source (output valid, kind, sweep_pos, query_y, left_x, left_y, right_x,
		right_y, input ready);
	modport sink (input valid, kind, sweep_pos, query_y, left_x, left_y, right_x,
		right_y, output ready);
endinterface
`default_nettype wire

[sv/pab_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_out_if: result channel
// Valid/ready channel carrying one breakpoint result.
// ----------------------------------------------------------------------------
interface pab_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [pab_pkg::CW-1:0] break_y;
	logic signed [pab_pkg::CW-1:0] root_low;
	logic signed [pab_pkg::CW-1:0] root_high;
	logic                          roots_valid;
	logic                          site_left;
	logic                          saturated;

	modport source (output valid, break_y, root_low, root_high, roots_valid, site_left,
		saturated, input ready);
	modport sink (input valid, break_y, root_low, root_high, roots_valid, site_left,
		saturated, output ready);
endinterface
`default_nettype wire

[sv/pab_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_front: query intake and classification
// Holds the sweep offset, places the sweep line and forms the site deltas.
// ----------------------------------------------------------------------------
module pab_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [pab_pkg::OFFW-1:0]  cfg_wdata,
	pab_in_if.sink                         item,
	input  wire logic                      fq_ready,
	output logic                           push,
	output pab_pkg::fq_rec_t               rec
);
	logic [pab_pkg::OFFW-1:0]        offset_q;
	logic signed [pab_pkg::UW-1:0]   sp_w;
	logic signed [pab_pkg::UW-1:0]   lx_w;
	logic signed [pab_pkg::UW-1:0]   x1_w;
	logic signed [pab_pkg::UW-1:0]   x2_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= pab_pkg::OFF_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	assign item.ready = fq_ready;
	assign push       = item.valid & fq_ready;

	always_comb begin
		sp_w = pab_pkg::UW'(item.sweep_pos);
		x1_w = pab_pkg::UW'(item.left_x);
		x2_w = pab_pkg::UW'(item.right_x);
		lx_w = item.kind ? sp_w - $signed({{(pab_pkg::UW-pab_pkg::OFFW){1'b0}}, offset_q})
			: sp_w;
		rec.side = item.kind;
		rec.eq   = item.left_x == item.right_x;
		rec.xlt  = item.left_x < item.right_x;
		rec.qy   = item.query_y;
		rec.p1y  = item.left_y;
		rec.p2y  = item.right_y;
		rec.u    = x1_w - lx_w;
		rec.v    = x2_w - lx_w;
		rec.a    = pab_pkg::AW'(x2_w - x1_w);
	end
endmodule
`default_nettype wire

[sv/pab_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_fifo: query queue
// Short queue that decouples intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module pab_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pab_pkg::fq_rec_t wr_rec,
	output logic                  not_full,
	input  wire logic             pop,
	output logic                  not_empty,
	output pab_pkg::fq_rec_t      rd_rec
);
	pab_pkg::fq_rec_t            mem_q [pab_pkg::FQ_DEPTH];
	logic [pab_pkg::FQ_AW-1:0]   wr_ptr_q;
	logic [pab_pkg::FQ_AW-1:0]   rd_ptr_q;
	logic [pab_pkg::FQ_AW:0]     count_q;

	assign not_full  = count_q != (pab_pkg::FQ_AW+1)'(pab_pkg::FQ_DEPTH);
	assign not_empty = count_q != '0;
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/pab_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_isqrt: pipelined integer square root
// One root bit per stage, floor of the root of the radicand.
// ----------------------------------------------------------------------------
module pab_isqrt (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   vin,
	input  wire logic [pab_pkg::RADW-1:0] rad,
	input  wire pab_pkg::sq_side_t      side_in,
	output logic                        vout,
	output logic [pab_pkg::SQW-1:0]     root,
	output pab_pkg::sq_side_t           side_out
);
	localparam int N = pab_pkg::SQW;

	logic                        v_s    [N];
	logic [pab_pkg::SQW-1:0]     root_s [N];
	pab_pkg::sq_side_t           side_s [N];
	logic [pab_pkg::RW-1:0]      rem_s  [N-1];
	logic [pab_pkg::RADW-1:0]    rad_s  [N-1];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic                      v_p;
		logic [pab_pkg::SQW-1:0]   root_p;
		pab_pkg::sq_side_t         side_p;
		logic [pab_pkg::RW-1:0]    rem_p;
		logic [pab_pkg::RADW-1:0]  rad_p;
		logic [pab_pkg::RW+1:0]    sh;
		logic [pab_pkg::RW+1:0]    trial;
		logic [pab_pkg::RW+1:0]    diff;
		logic                      ge;

		if (k == 0) begin : g_first
			assign v_p    = vin;
			assign root_p = '0;
			assign side_p = side_in;
			assign rem_p  = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign root_p = root_s[k-1];
			assign side_p = side_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		assign sh    = {rem_p, rad_p[pab_pkg::RADW-1 -: 2]};
		assign trial = (pab_pkg::RW+2)'({root_p, 2'b01});
		assign ge    = sh >= trial;
		assign diff  = sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_p[pab_pkg::SQW-2:0], ge};
				side_s[k] <= side_p;
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[pab_pkg::RW-1:0] : sh[pab_pkg::RW-1:0];
					rad_s[k] <= rad_p << 2;
				end
			end
		end
	end

	assign vout     = v_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

[sv/pab_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_div: pipelined dual restoring divider
// Divides both root numerators by the shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pab_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    vin,
	input  wire logic [pab_pkg::NMW-1:0] num_p,
	input  wire logic [pab_pkg::NMW-1:0] num_n,
	input  wire logic [pab_pkg::DMW-1:0] den,
	input  wire pab_pkg::dv_side_t       side_in,
	output logic                         vout,
	output logic [pab_pkg::NMW-1:0]      q_p,
	output logic [pab_pkg::NMW-1:0]      q_n,
	output pab_pkg::dv_side_t            side_out
);
	localparam int N = pab_pkg::NMW;

	logic                        v_s    [N];
	logic [pab_pkg::NMW-1:0]     np_s   [N];
	logic [pab_pkg::NMW-1:0]     nn_s   [N];
	pab_pkg::dv_side_t           side_s [N];
	logic [pab_pkg::DMW-1:0]     rp_s   [N-1];
	logic [pab_pkg::DMW-1:0]     rn_s   [N-1];
	logic [pab_pkg::DMW-1:0]     d_s    [N-1];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic                      v_p;
		logic [pab_pkg::NMW-1:0]   np_p;
		logic [pab_pkg::NMW-1:0]   nn_p;
		pab_pkg::dv_side_t         side_p;
		logic [pab_pkg::DMW-1:0]   rp_p;
		logic [pab_pkg::DMW-1:0]   rn_p;
		logic [pab_pkg::DMW-1:0]   d_p;
		logic [pab_pkg::DMW:0]     shp;
		logic [pab_pkg::DMW:0]     shn;
		logic [pab_pkg::DMW:0]     dx;
		logic                      gep;
		logic                      gen;

		if (k == 0) begin : g_first
			assign v_p    = vin;
			assign np_p   = num_p;
			assign nn_p   = num_n;
			assign side_p = side_in;
			assign rp_p   = '0;
			assign rn_p   = '0;
			assign d_p    = den;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign np_p   = np_s[k-1];
			assign nn_p   = nn_s[k-1];
			assign side_p = side_s[k-1];
			assign rp_p   = rp_s[k-1];
			assign rn_p   = rn_s[k-1];
			assign d_p    = d_s[k-1];
		end

		assign shp = {rp_p, np_p[pab_pkg::NMW-1]};
		assign shn = {rn_p, nn_p[pab_pkg::NMW-1]};
		assign dx  = {1'b0, d_p};
		assign gep = shp >= dx;
		assign gen = shn >= dx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				np_s[k]   <= {np_p[pab_pkg::NMW-2:0], gep};
				nn_s[k]   <= {nn_p[pab_pkg::NMW-2:0], gen};
				side_s[k] <= side_p;
			end
		end

		if (k < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rp_s[k] <= gep ? pab_pkg::DMW'(shp - dx) : shp[pab_pkg::DMW-1:0];
					rn_s[k] <= gen ? pab_pkg::DMW'(shn - dx) : shn[pab_pkg::DMW-1:0];
					d_s[k]  <= d_p;
				end
			end
		end
	end

	assign vout     = v_s[N-1];
	assign q_p      = np_s[N-1];
	assign q_n      = nn_s[N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

[sv/pab_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_back: breakpoint arithmetic pipeline
// Products, radicand, square root, division, saturation and root selection.
// ----------------------------------------------------------------------------
module pab_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fq_valid,
	input  wire pab_pkg::fq_rec_t fq_rec,
	output logic                  pop,
	pab_out_if.source             result
);
	localparam int CW  = pab_pkg::CW;
	localparam int HW  = pab_pkg::HW;
	localparam int PW  = pab_pkg::UW + CW;

	typedef struct packed {
		logic signed [CW-1:0] val;
		logic                 hi;
		logic                 lo;
	} rs_t;

	logic en;

	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PW-1:0]        t1_s1, t2_s1;
	logic [pab_pkg::DDW-1:0]     dx2_s1, dy2_s1, dd_s2;
	logic [pab_pkg::UVW-1:0]     uv_s1, uv_s2;
	logic [2*HW-1:0]             hh_s3, hl_s3, lh_s3, ll_s3;
	logic [pab_pkg::RADW-1:0]    rad_s4;
	logic signed [pab_pkg::BW-1:0] b_s2;
	pab_pkg::sq_side_t           sd_s1, sd_s2, sd_s3, sd_s4;
	pab_pkg::sq_side_t           sd2_w;
	logic [pab_pkg::NMW-1:0]     np_s5, nn_s5;
	logic [pab_pkg::DMW-1:0]     d_s5;
	pab_pkg::dv_side_t           dv_s5;

	logic                        v_q;
	logic signed [CW-1:0]        brk_q, lo_q, hi_q;
	logic                        rv_q, left_q, sat_q;

	logic signed [pab_pkg::UW-1:0] umag_w, vmag_w;
	logic                        same_w;
	logic signed [CW:0]          dy_w, ysum_w;
	logic signed [PW-1:0]        t1_w, t2_w;
	logic signed [2*pab_pkg::AW-1:0] dx2_w;
	logic signed [2*CW+1:0]      dy2_w;
	logic [pab_pkg::AW-1:0]      amag_w;

	logic                        sq_v;
	logic [pab_pkg::SQW-1:0]     sq_root;
	pab_pkg::sq_side_t           sq_side;
	logic signed [pab_pkg::NW-1:0] np_w, nn_w, npa_w, nna_w;

	logic                        dv_v;
	logic [pab_pkg::NMW-1:0]     qp_w, qn_w;
	pab_pkg::dv_side_t           dv_side;
	rs_t                         rp_w, rn_w, rlo_w, rhi_w, rb_w;
	logic signed [CW-1:0]        brk_w;
	logic                        left_w;

	function automatic rs_t sat_root(logic [pab_pkg::NMW-1:0] q, logic neg);
		rs_t r;
		r.hi = 1'b0;
		r.lo = 1'b0;
		if (!neg) begin
			if (q > pab_pkg::NMW'({1'b0, {(CW-1){1'b1}}})) begin
				r.val = {1'b0, {(CW-1){1'b1}}};
				r.hi  = 1'b1;
			end else begin
				r.val = q[CW-1:0];
			end
		end else begin
			if (q > pab_pkg::NMW'({1'b1, {(CW-1){1'b0}}})) begin
				r.val = {1'b1, {(CW-1){1'b0}}};
				r.lo  = 1'b1;
			end else begin
				r.val = -q[CW-1:0];
			end
		end
		return r;
	endfunction

	assign en  = !v_q || result.ready;
	assign pop = en && fq_valid;

	always_comb begin
		umag_w = fq_rec.u[pab_pkg::UW-1] ? -fq_rec.u : fq_rec.u;
		vmag_w = fq_rec.v[pab_pkg::UW-1] ? -fq_rec.v : fq_rec.v;
		same_w = (fq_rec.u > 0 && fq_rec.v > 0) || (fq_rec.u < 0 && fq_rec.v < 0);
		t1_w   = fq_rec.v * fq_rec.p1y;
		t2_w   = fq_rec.u * fq_rec.p2y;
		dx2_w  = fq_rec.a * fq_rec.a;
		dy_w   = fq_rec.p1y - fq_rec.p2y;
		dy2_w  = dy_w * dy_w;
		ysum_w = fq_rec.p1y + fq_rec.p2y;
		amag_w = fq_rec.a[pab_pkg::AW-1] ? -fq_rec.a : fq_rec.a;
	end

	always_comb begin
		sd2_w   = sd_s2;
		sd2_w.b = b_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1 <= fq_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= sq_v;
			v_q  <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1        <= t1_w;
			t2_s1        <= t2_w;
			dx2_s1       <= pab_pkg::DDW'(dx2_w);
			dy2_s1       <= pab_pkg::DDW'(dy2_w);
			uv_s1        <= same_w ? umag_w[HW-1:0] * vmag_w[HW-1:0] : '0;
			sd_s1.side   <= fq_rec.side;
			sd_s1.eq     <= fq_rec.eq;
			sd_s1.xlt    <= fq_rec.xlt;
			sd_s1.asign  <= fq_rec.a[pab_pkg::AW-1];
			sd_s1.amag   <= amag_w[pab_pkg::DMW-1:0];
			sd_s1.qy     <= fq_rec.qy;
			sd_s1.mean   <= ysum_w[CW:1];
			sd_s1.b      <= '0;

			b_s2         <= pab_pkg::BW'(t1_s1) - pab_pkg::BW'(t2_s1);
			dd_s2        <= dx2_s1 + dy2_s1;
			uv_s2        <= uv_s1;
			sd_s2        <= sd_s1;

			hh_s3        <= uv_s2[2*HW-1:HW] * dd_s2[2*HW-1:HW];
			hl_s3        <= uv_s2[2*HW-1:HW] * dd_s2[HW-1:0];
			lh_s3        <= uv_s2[HW-1:0] * dd_s2[2*HW-1:HW];
			ll_s3        <= uv_s2[HW-1:0] * dd_s2[HW-1:0];
			sd_s3        <= sd2_w;

			rad_s4       <= ({hh_s3, {(2*HW){1'b0}}})
				+ (pab_pkg::RADW'({1'b0, hl_s3} + {1'b0, lh_s3}) << HW)
				+ pab_pkg::RADW'(ll_s3);
			sd_s4        <= sd_s3;
		end
	end

	pab_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s4),
		.rad      (rad_s4),
		.side_in  (sd_s4),
		.vout     (sq_v),
		.root     (sq_root),
		.side_out (sq_side)
	);

	always_comb begin
		np_w  = pab_pkg::NW'(sq_side.b) + $signed({1'b0, pab_pkg::NMW'(sq_root)});
		nn_w  = pab_pkg::NW'(sq_side.b) - $signed({1'b0, pab_pkg::NMW'(sq_root)});
		npa_w = np_w[pab_pkg::NW-1] ? -np_w : np_w;
		nna_w = nn_w[pab_pkg::NW-1] ? -nn_w : nn_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s5       <= npa_w[pab_pkg::NMW-1:0];
			nn_s5       <= nna_w[pab_pkg::NMW-1:0];
			d_s5        <= sq_side.amag;
			dv_s5.side  <= sq_side.side;
			dv_s5.eq    <= sq_side.eq;
			dv_s5.xlt   <= sq_side.xlt;
			dv_s5.neg_p <= np_w[pab_pkg::NW-1] ^ sq_side.asign;
			dv_s5.neg_n <= nn_w[pab_pkg::NW-1] ^ sq_side.asign;
			dv_s5.qy    <= sq_side.qy;
			dv_s5.mean  <= sq_side.mean;
		end
	end

	pab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (v_s5),
		.num_p    (np_s5),
		.num_n    (nn_s5),
		.den      (d_s5),
		.side_in  (dv_s5),
		.vout     (dv_v),
		.q_p      (qp_w),
		.q_n      (qn_w),
		.side_out (dv_side)
	);

	always_comb begin
		rp_w = sat_root(qp_w, dv_side.neg_p);
		rn_w = sat_root(qn_w, dv_side.neg_n);
		if (rp_w.val <= rn_w.val) begin
			rlo_w = rp_w;
			rhi_w = rn_w;
		end else begin
			rlo_w = rn_w;
			rhi_w = rp_w;
		end
		rb_w = dv_side.xlt ? rhi_w : rlo_w;
		if (dv_side.eq) begin
			brk_w  = dv_side.mean;
			left_w = dv_side.side && (dv_side.qy < dv_side.mean);
		end else begin
			brk_w  = rb_w.val;
			left_w = dv_side.side && (rb_w.hi || (!rb_w.lo && (dv_side.qy < rb_w.val)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			brk_q  <= brk_w;
			lo_q   <= dv_side.eq ? '0 : rlo_w.val;
			hi_q   <= dv_side.eq ? '0 : rhi_w.val;
			rv_q   <= !dv_side.eq;
			left_q <= left_w;
			sat_q  <= !dv_side.eq && (rp_w.hi || rp_w.lo || rn_w.hi || rn_w.lo);
		end
	end

	assign result.valid       = v_q;
	assign result.break_y     = brk_q;
	assign result.root_low    = lo_q;
	assign result.root_high   = hi_q;
	assign result.roots_valid = rv_q;
	assign result.site_left   = left_q;
	assign result.saturated   = sat_q;
endmodule
`default_nettype wire

[sv/parabolic_arc_breakpoint_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// parabolic_arc_breakpoint_core: beach-line breakpoint between two arcs
// Exact fixed-point breakpoint and side test for a sweep-line Voronoi build.
//
//   channel   direction  handshake        content
//   item      in         valid / ready    kind, sweep, query y, two sites
//   result    out        valid / ready    breakpoint, roots, flags
//   cfg       in         cfg_we           sweep offset
//
// One transaction is taken per cycle while the queue is not full, and each result
// passes four product stages, 66 square root stages, one numerator stage,
// 68 divider stages and the output register. A stalled result holds the whole
// pipeline, while a four-entry queue keeps taking transactions until it fills.
// Reset clears the valid bits, the queue and sets the sweep offset to one.
// ----------------------------------------------------------------------------
module parabolic_arc_breakpoint_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [pab_pkg::OFFW-1:0]  cfg_wdata,
	pab_in_if.sink                         item,
	pab_out_if.source                      result
);
	logic             push;
	logic             not_full;
	logic             not_empty;
	logic             pop;
	pab_pkg::fq_rec_t wr_rec;
	pab_pkg::fq_rec_t rd_rec;

	pab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.fq_ready  (not_full),
		.push      (push),
		.rec       (wr_rec)
	);

	pab_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_rec    (rd_rec)
	);

	pab_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_valid (not_empty),
		.fq_rec   (rd_rec),
		.pop      (pop),
		.result   (result)
	);
endmodule
`default_nettype wire

[sv/pab_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pab_checker: port-level assertions
// Result consistency and output stall behavior seen at the top level.
// ----------------------------------------------------------------------------
module pab_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic signed [pab_pkg::CW-1:0] break_y,
	input wire logic signed [pab_pkg::CW-1:0] root_low,
	input wire logic signed [pab_pkg::CW-1:0] root_high,
	input wire logic                          roots_valid,
	input wire logic                          saturated
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(break_y) && $stable(root_low)
			&& $stable(root_high))
		else $error("Stalled result changed.");

	a_midpoint: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !roots_valid |-> root_low == '0 && root_high == '0 && !saturated)
		else $error("Equal-x result carries roots or saturation.");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && roots_valid |-> root_low <= root_high)
		else $error("Roots out of order.");

	a_choice: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && roots_valid |-> break_y == root_low || break_y == root_high)
		else $error("Breakpoint is neither root.");
endmodule

bind parabolic_arc_breakpoint_core pab_checker u_pab_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.break_y     (result.break_y),
	.root_low    (result.root_low),
	.root_high   (result.root_high),
	.roots_valid (result.roots_valid),
	.saturated   (result.saturated)
);
`default_nettype wire
